FILE: rtl/core/qrs_pkg.sv
// Package for the quadratic root solver: controller states, command and status types.
// No dependencies.
package qrs_pkg;
    localparam int SQRT_GUARD = 12;
    localparam int DISC_W = 34;
    localparam int RAD_W = DISC_W + 2 * SQRT_GUARD;
    localparam int ROOT_W = RAD_W / 2;
    localparam int NUM_W = ROOT_W + 2;
    localparam int DEN_W = 17 + SQRT_GUARD + 1;
    localparam int SAT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISC,
        ST_SQRT,
        ST_DIVP,
        ST_DIVM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic disc;
        logic sqrt_start;
        logic sqrt_step;
        logic divp_start;
        logic divm_start;
        logic div_step;
        logic divp_take;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic degenerate;
        logic disc_neg;
        logic sqrt_done;
        logic div_done;
    } stat_t;
endpackage

FILE: rtl/core/qrs_datapath.sv
// Datapath of the quadratic root solver: discriminant, bit-serial square root, restoring divider.
// Depends on qrs_pkg.
module qrs_datapath #(
    parameter int ROOT_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [47:0]         in_data,
    input  qrs_pkg::cmd_t       cmd,
    output qrs_pkg::stat_t      stat,
    output logic [31:0]         root_plus,
    output logic [31:0]         root_minus,
    output logic [31:0]         real_count
);
    import qrs_pkg::*;

    localparam int MN_W = NUM_W + ROOT_FRAC_BITS;
    localparam int QCW = $clog2(MN_W + 1);
    localparam int SCW = $clog2(ROOT_W + 1);

    logic signed [15:0] a_reg, b_reg, c_reg;
    logic signed [DISC_W-1:0] disc_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] s_reg;
    logic [SCW-1:0] scnt_reg;
    logic [MN_W-1:0] quo_reg;
    logic [DEN_W-1:0] dr_reg;
    logic [DEN_W-1:0] md_reg;
    logic neg_reg;
    logic [QCW-1:0] qcnt_reg;
    logic [31:0] rp_reg, rm_reg, cnt_reg;
    logic [ROOT_W+1:0] trial;
    logic [DEN_W:0] dtrial;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0] mn;
    logic signed [DEN_W-1:0] den;
    logic [31:0] sat;
    logic signed [DISC_W-1:0] bb, ac4;
    logic signed [DISC_W-1:0] disc_val;

    assign bb = DISC_W'(b_reg * b_reg);
    assign ac4 = DISC_W'(a_reg * c_reg) <<< 2;
    assign disc_val = bb - ac4;
    assign den = DEN_W'(signed'(a_reg)) <<< (SQRT_GUARD + 1);
    assign num = cmd.divp_start
        ? (NUM_W'(-(NUM_W'(b_reg))) <<< SQRT_GUARD) + NUM_W'({2'b00, s_reg})
        : (NUM_W'(-(NUM_W'(b_reg))) <<< SQRT_GUARD) - NUM_W'({2'b00, s_reg});
    assign mn = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign trial = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]} - {s_reg, 2'b01};
    assign dtrial = {dr_reg, quo_reg[MN_W-1]} - {1'b0, md_reg};

    always_comb
    begin
        if (neg_reg)
            sat = (|quo_reg[MN_W-1:31]) ? 32'h8000_0000 : 32'(-quo_reg[31:0]);
        else
            sat = (|quo_reg[MN_W-1:31]) ? SAT_MAX : quo_reg[31:0];
    end

    assign stat.degenerate = (a_reg == 16'sd0);
    assign stat.disc_neg = disc_reg[DISC_W-1];
    assign stat.sqrt_done = (scnt_reg == SCW'(ROOT_W - 1));
    assign stat.div_done = (qcnt_reg == QCW'(MN_W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= in_data[15:0];
            b_reg <= in_data[31:16];
            c_reg <= in_data[47:32];
        end
        if (cmd.disc)
            disc_reg <= disc_val;
        if (cmd.sqrt_start)
        begin
            rad_reg <= RAD_W'(disc_val) << (2 * SQRT_GUARD);
            rem_reg <= '0;
            s_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (!trial[ROOT_W+1])
            begin
                rem_reg <= trial;
                s_reg <= {s_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
                s_reg <= {s_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.divp_start || cmd.divm_start)
        begin
            quo_reg <= {mn, {ROOT_FRAC_BITS{1'b0}}};
            dr_reg <= '0;
            md_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (cmd.div_step)
        begin
            if (!dtrial[DEN_W])
            begin
                dr_reg <= dtrial[DEN_W-1:0];
                quo_reg <= {quo_reg[MN_W-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[DEN_W-2:0], quo_reg[MN_W-1]};
                quo_reg <= {quo_reg[MN_W-2:0], 1'b0};
            end
        end
        if (cmd.divp_take)
            rp_reg <= sat;
        if (cmd.finish)
            rm_reg <= sat;
        if (cmd.disc)
        begin
            rp_reg <= '0;
            rm_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            scnt_reg <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            if (cmd.sqrt_start)
                scnt_reg <= '0;
            else if (cmd.sqrt_step)
                scnt_reg <= scnt_reg + 1'b1;
            if (cmd.divp_start || cmd.divm_start)
                qcnt_reg <= '0;
            else if (cmd.div_step)
                qcnt_reg <= qcnt_reg + 1'b1;
            if (cmd.finish && cnt_reg != 32'hFFFF_FFFF)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign root_plus = rp_reg;
    assign root_minus = rm_reg;
    assign real_count = cnt_reg;
endmodule

FILE: rtl/core/qrs_ctrl.sv
// Controller state machine of the quadratic root solver, including the result handshake.
// Depends on qrs_pkg.
module qrs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_ready,
    input  qrs_pkg::stat_t  stat,
    output qrs_pkg::cmd_t   cmd,
    output logic            idle,
    output logic            out_valid,
    output logic            real_flag,
    output logic            degen_flag
);
    import qrs_pkg::*;

    state_t state_reg, state_next;
    logic real_reg, real_next, degen_reg, degen_next;
    logic div_cont_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            real_reg <= 1'b0;
            degen_reg <= 1'b0;
            div_cont_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            real_reg <= real_next;
            degen_reg <= degen_next;
            div_cont_reg <= cmd.divp_start || cmd.divm_start || (cmd.div_step && !stat.div_done);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        real_next = real_reg;
        degen_next = degen_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DISC;
                end
            end
            ST_DISC:
            begin
                cmd.disc = 1'b1;
                state_next = ST_SQRT;
                cmd.sqrt_start = 1'b1;
                degen_next = stat.degenerate;
                real_next = 1'b0;
            end
            ST_SQRT:
            begin
                if (stat.degenerate || stat.disc_neg)
                    state_next = ST_OUT;
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    if (stat.sqrt_done)
                        state_next = ST_DIVP;
                end
            end
            ST_DIVP:
            begin
                if (!div_cont_reg)
                    cmd.divp_start = 1'b1;
                else if (stat.div_done)
                begin
                    cmd.div_step = 1'b1;
                    state_next = ST_DIVM;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_DIVM:
            begin
                if (!div_cont_reg)
                begin
                    cmd.divp_take = 1'b1;
                    cmd.divm_start = 1'b1;
                end
                else if (stat.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                    cmd.div_step = 1'b1;
                if (div_cont_reg && stat.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!real_reg && !stat.degenerate && !stat.disc_neg && !div_cont_reg)
                begin
                    cmd.finish = 1'b1;
                    real_next = 1'b1;
                end
                else if (out_ready && (real_reg || stat.degenerate || stat.disc_neg))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign idle = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT) && (real_reg || degen_reg || stat.disc_neg);
    assign real_flag = real_reg;
    assign degen_flag = degen_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |-> idle)
        else $error("load outside idle");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n) !(real_reg && degen_reg))
        else $error("real and degenerate together");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> real_reg)
        else $error("finish without flag");
endmodule

FILE: rtl/core/quadratic_root_solver.sv
// Top level of the quadratic root solver: stream ports, controller and datapath.
// Depends on qrs_pkg, qrs_ctrl and qrs_datapath.
// One request at a time: an item with real roots passes through an accept state, a discriminant
// state, the square-root steps, two divisions (each a set-up step and then the quotient steps)
// and the output state; the bit-serial square root and the shared restoring divider set its
// length. Items with a zero a or a negative discriminant skip the square-root steps and the
// divisions. A new request is taken once the previous result has been taken.
module quadratic_root_solver #(
    parameter int ROOT_FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,  // coef_a, coef_b, coef_c
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // root_plus, root_minus, real_count
    output logic [1:0]   m_tuser   // has_real_roots, degenerate
);
    import qrs_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic idle, real_flag, degen_flag;
    logic [31:0] rp, rm, cnt;

    assign s_tready = idle;

    qrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && idle), .out_ready(m_tready),
        .stat(stat), .cmd(cmd), .idle(idle), .out_valid(m_tvalid),
        .real_flag(real_flag), .degen_flag(degen_flag)
    );

    qrs_datapath #(.ROOT_FRAC_BITS(ROOT_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(s_tdata), .cmd(cmd), .stat(stat),
        .root_plus(rp), .root_minus(rm), .real_count(cnt)
    );

    assign m_tdata = {cnt, rm, rp};
    assign m_tuser = {degen_flag, real_flag};
endmodule
